// File: sv/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int TICK_WIDTH_DEF = 16;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_CREATE   = 3'd1;
    localparam logic [2:0] OP_START    = 3'd2;
    localparam logic [2:0] OP_RESTART  = 3'd3;
    localparam logic [2:0] OP_SET_PRED = 3'd4;

    localparam logic [2:0] KIND_CYCLIC        = 3'd0;
    localparam logic [2:0] KIND_ONE_TIME      = 3'd1;
    localparam logic [2:0] KIND_TRIGGER       = 3'd2;
    localparam logic [2:0] KIND_FOLLOW_CYCLIC = 3'd3;
    localparam logic [2:0] KIND_FOLLOW_ONCE   = 3'd4;

    localparam logic [1:0] RS_RUN   = 2'd0;
    localparam logic [1:0] RS_WAIT  = 2'd1;
    localparam logic [1:0] RS_DONE  = 2'd2;
    localparam logic [1:0] RS_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_WALK,
        ST_FIN
    } tts_state_t;

    typedef struct packed {
        logic accept;
        logic busy;
        logic cmd_en;
        logic walk_en;
        logic fin_en;
    } tts_ctrl_t;

endpackage

// File: sv/tts_ram.sv
`timescale 1ns / 1ps

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tts_seq.sv
`timescale 1ns / 1ps

module tts_seq #(
    parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         is_tick,
    input  logic                         out_free,
    output tts_pkg::tts_ctrl_t           ctrl,
    output logic [$clog2(NUM_SLOTS)-1:0] idx
);

    import tts_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    tts_state_t    state_reg;
    tts_state_t    state_next;
    logic [SW-1:0] idx_reg;
    logic [SW-1:0] idx_next;
    logic          last;

    assign last = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = is_tick ? ST_WALK : ST_CMD;
                end
            end
            ST_CMD:
            begin
                state_next = ST_FIN;
            end
            ST_WALK:
            begin
                if (last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.accept = in_valid;
            end
            ST_CMD:
            begin
                ctrl.busy   = 1'b1;
                ctrl.cmd_en = 1'b1;
            end
            ST_WALK:
            begin
                ctrl.busy    = 1'b1;
                ctrl.walk_en = 1'b1;
            end
            ST_FIN:
            begin
                ctrl.busy   = 1'b1;
                ctrl.fin_en = out_free;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.accept)
        begin
            idx_next = '0;
        end
        else if (ctrl.walk_en)
        begin
            idx_next = SW'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

// File: sv/tick_task_timer_slots_core.sv
`timescale 1ns / 1ps
// A command passes through the command state to the finish state, which registers its result
// once the output is free; no new item is taken until then.
// A tick reads and rewrites one slot record per cycle through the slot RAM in the walk state,
// and its result is registered in the finish state once the output is free.
// Reset clears every slot to empty at once; the RAM needs no clearing pass.

module tick_task_timer_slots_core #(
    parameter int NUM_SLOTS  = tts_pkg::NUM_SLOTS_DEF,
    parameter int TICK_WIDTH = tts_pkg::TICK_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [2:0]  task_type,
    input  logic [15:0] reload_ticks,
    input  logic [3:0]  prev_slot,
    input  logic        prev_enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] fired_mask,
    output logic [1:0]  slot_state,
    output logic        accepted
);

    import tts_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int TW = TICK_WIDTH;
    localparam int RW = 8 + 2 * TW;
    localparam logic [7:0]  NSLOT8 = 8'(NUM_SLOTS);
    localparam logic [31:0] TMAX   = 32'((64'd1 << TW) - 64'd1);

    tts_ctrl_t ctrl;
    logic [SW-1:0] idx;
    logic          out_free;

    logic [2:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [2:0]  type_reg;
    logic [15:0] reload_reg;
    logic [3:0]  prev_slot_reg;
    logic        prev_en_reg;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] wait_reg, wait_next;
    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic [15:0]          mask_reg, mask_next;
    logic                 acc_reg, acc_next;

    logic        out_valid_reg;
    logic [15:0] fired_mask_reg;
    logic [1:0]  slot_state_reg;
    logic        accepted_reg;

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [SW-1:0] mem_raddr;
    logic [RW-1:0] mem_wdata;
    logic [RW-1:0] mem_rdata;

    logic [2:0]    rd_kind;
    logic [TW-1:0] rd_reload;
    logic [TW-1:0] rd_count;
    logic          rd_pred_en;
    logic [3:0]    rd_pred;

    logic [2:0]    wr_kind;
    logic [TW-1:0] wr_reload;
    logic [TW-1:0] wr_count;
    logic          wr_pred_en;
    logic [3:0]    wr_pred;

    logic [SW-1:0] slot_idx;
    logic          slot_in;
    logic          s_valid;
    logic          s_wait;
    logic          s_done;
    logic [1:0]    s_state;
    logic [31:0]   reload32;
    logic [TW-1:0] reload_sat;

    logic [SW-1:0] pred_idx;
    logic          pred_in;
    logic          pred_done;
    logic          follow;
    logic          running;
    logic          blocked;

    tts_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_tick  (opcode == OP_TICK),
        .out_free (out_free),
        .ctrl     (ctrl),
        .idx      (idx)
    );

    tts_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = ctrl.busy;
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_pred    = mem_rdata[3:0];
    assign rd_pred_en = mem_rdata[4];
    assign rd_count   = mem_rdata[5 +: TW];
    assign rd_reload  = mem_rdata[5 + TW +: TW];
    assign rd_kind    = mem_rdata[5 + 2 * TW +: 3];
    assign mem_wdata  = {wr_kind, wr_reload, wr_count, wr_pred_en, wr_pred};

    assign slot_idx = SW'(slot_reg);
    assign slot_in  = (8'(slot_reg) < NSLOT8);
    assign s_valid  = slot_in && valid_reg[slot_idx];
    assign s_wait   = s_valid && wait_reg[slot_idx];
    assign s_done   = s_valid && done_reg[slot_idx];

    always_comb
    begin
        if (!s_valid)
        begin
            s_state = RS_EMPTY;
        end
        else if (s_done)
        begin
            s_state = RS_DONE;
        end
        else if (s_wait)
        begin
            s_state = RS_WAIT;
        end
        else
        begin
            s_state = RS_RUN;
        end
    end

    assign reload32   = 32'(reload_reg);
    assign reload_sat = (reload32 > TMAX) ? TW'(TMAX) : TW'(reload32);

    assign pred_idx  = SW'(rd_pred);
    assign pred_in   = (8'(rd_pred) < NSLOT8);
    assign pred_done = pred_in && valid_reg[pred_idx] && done_reg[pred_idx];
    assign follow    = (rd_kind == KIND_FOLLOW_CYCLIC) || (rd_kind == KIND_FOLLOW_ONCE);
    assign running   = valid_reg[idx] && !wait_reg[idx] && !done_reg[idx];
    assign blocked   = follow && rd_pred_en && !pred_done;

    always_comb
    begin
        mem_raddr = idx + 1'b1;
        if (ctrl.accept)
        begin
            mem_raddr = (opcode == OP_TICK) ? '0 : SW'(slot);
        end
    end

    assign mem_waddr = ctrl.walk_en ? idx : slot_idx;

    always_comb
    begin
        valid_next = valid_reg;
        wait_next  = wait_reg;
        done_next  = done_reg;
        mask_next  = mask_reg;
        acc_next   = acc_reg;
        mem_we     = 1'b0;
        wr_kind    = rd_kind;
        wr_reload  = rd_reload;
        wr_count   = rd_count;
        wr_pred_en = rd_pred_en;
        wr_pred    = rd_pred;

        if (ctrl.accept)
        begin
            mask_next = '0;
            acc_next  = (opcode == OP_TICK);
        end

        if (ctrl.cmd_en)
        begin
            case (op_reg)
                OP_CREATE:
                begin
                    if (slot_in)
                    begin
                        mem_we               = 1'b1;
                        wr_kind              = type_reg;
                        wr_reload            = reload_sat;
                        wr_count             = reload_sat;
                        wr_pred_en           = 1'b0;
                        wr_pred              = '0;
                        valid_next[slot_idx] = 1'b1;
                        wait_next[slot_idx]  = (type_reg == KIND_TRIGGER);
                        done_next[slot_idx]  = 1'b0;
                        acc_next             = 1'b1;
                    end
                end
                OP_START:
                begin
                    if (s_wait)
                    begin
                        mem_we              = 1'b1;
                        wr_count            = rd_reload;
                        wait_next[slot_idx] = 1'b0;
                        acc_next            = 1'b1;
                    end
                end
                OP_RESTART:
                begin
                    if (s_valid && !s_done)
                    begin
                        mem_we              = 1'b1;
                        wr_count            = rd_reload;
                        wait_next[slot_idx] = 1'b0;
                        acc_next            = 1'b1;
                    end
                end
                OP_SET_PRED:
                begin
                    if (s_valid)
                    begin
                        mem_we     = 1'b1;
                        wr_pred_en = prev_en_reg;
                        wr_pred    = prev_en_reg ? prev_slot_reg : 4'd0;
                        acc_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctrl.walk_en && running && !blocked)
        begin
            mem_we = 1'b1;
            if (rd_count <= TW'(1))
            begin
                mask_next = mask_reg | (16'd1 << idx);
                if ((rd_kind == KIND_CYCLIC) || (rd_kind == KIND_FOLLOW_CYCLIC))
                begin
                    wr_count = rd_reload;
                end
                else if (rd_kind == KIND_TRIGGER)
                begin
                    wr_count       = '0;
                    wait_next[idx] = 1'b1;
                end
                else
                begin
                    wr_count       = '0;
                    done_next[idx] = 1'b1;
                end
            end
            else
            begin
                wr_count = rd_count - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wait_reg      <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
            if (ctrl.fin_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        acc_reg  <= acc_next;
        if (ctrl.accept)
        begin
            op_reg        <= opcode;
            slot_reg      <= slot;
            type_reg      <= task_type;
            reload_reg    <= reload_ticks;
            prev_slot_reg <= prev_slot;
            prev_en_reg   <= prev_enable;
        end
        if (ctrl.fin_en)
        begin
            fired_mask_reg <= mask_reg;
            slot_state_reg <= s_state;
            accepted_reg   <= acc_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired_mask = fired_mask_reg;
    assign slot_state = slot_state_reg;
    assign accepted   = accepted_reg;

endmodule

// File: sv/tts_checker.sv
`timescale 1ns / 1ps

module tts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] fired_mask,
    input logic        accepted
);

    // A result that is held back stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // One item is in work at a time, so a transfer closes the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    // A new result only appears while an item was in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

    // Only a tick fires slots, and a tick is always accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fired_mask != 16'd0) |-> accepted)
        else $error("fired slots on a refused command");

endmodule

bind tick_task_timer_slots_core tts_checker u_tts_checker (.*);

// File: tb/sv/tick_task_timer_slots_core_test.sv
`timescale 1ns / 1ps

module tick_task_timer_slots_core_test;

    import tts_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    typedef struct {
        logic [15:0] fired;
        logic [1:0]  status;
        logic        applied;
    } timer_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [3:0]  slot;
    logic [2:0]  task_type;
    logic [15:0] reload_ticks;
    logic [3:0]  prev_slot;
    logic        prev_enable;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] fired_mask;
    logic [1:0]  slot_state;
    logic        accepted;

    logic        tbl_used   [SLOTS];
    logic [2:0]  tbl_kind   [SLOTS];
    logic [15:0] tbl_reload [SLOTS];
    logic [16:0] tbl_count  [SLOTS];
    logic [1:0]  tbl_run    [SLOTS];
    logic [4:0]  tbl_pred   [SLOTS];

    timer_result_t pending_results[$];
    int error_count;
    int send_gap_pct;
    int recv_stall_pct;

    tick_task_timer_slots_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .slot         (slot),
        .task_type    (task_type),
        .reload_ticks (reload_ticks),
        .prev_slot    (prev_slot),
        .prev_enable  (prev_enable),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired_mask   (fired_mask),
        .slot_state   (slot_state),
        .accepted     (accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("tick_task_timer_slots_core test failed");
        $finish;
    end

    function automatic logic [1:0] slot_status(input logic [3:0] s);
        if (!tbl_used[s])
        begin
            return RS_EMPTY;
        end
        return tbl_run[s];
    endfunction

    // Slots are visited in ascending order, so a predecessor that finished
    // earlier in the same walk already counts as done.
    function automatic logic [15:0] walk_tick();
        logic [15:0] fired;
        logic [2:0]  k;
        fired = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!tbl_used[i] || tbl_run[i] != RS_RUN)
            begin
                continue;
            end
            k = tbl_kind[i];
            if ((k == KIND_FOLLOW_CYCLIC || k == KIND_FOLLOW_ONCE) && tbl_pred[i][4]
                && slot_status(tbl_pred[i][3:0]) != RS_DONE)
            begin
                continue;
            end
            if (tbl_count[i] <= 17'd1)
            begin
                fired[i] = 1'b1;
                if (k == KIND_CYCLIC || k == KIND_FOLLOW_CYCLIC)
                begin
                    tbl_count[i] = {1'b0, tbl_reload[i]};
                end
                else if (k == KIND_TRIGGER)
                begin
                    tbl_run[i]   = RS_WAIT;
                    tbl_count[i] = '0;
                end
                else
                begin
                    tbl_run[i]   = RS_DONE;
                    tbl_count[i] = '0;
                end
            end
            else
            begin
                tbl_count[i] = tbl_count[i] - 17'd1;
            end
        end
        return fired;
    endfunction

    function automatic timer_result_t apply_command(
        input logic [2:0]  op,
        input logic [3:0]  s,
        input logic [2:0]  k,
        input logic [15:0] r,
        input logic [3:0]  p,
        input logic        pe
    );
        timer_result_t res;
        logic [1:0]    cur;
        res.fired   = '0;
        res.applied = 1'b0;
        cur = slot_status(s);
        case (op)
            OP_TICK:
            begin
                res.fired   = walk_tick();
                res.applied = 1'b1;
            end
            OP_CREATE:
            begin
                tbl_used[s]   = 1'b1;
                tbl_kind[s]   = k;
                tbl_reload[s] = r;
                tbl_count[s]  = {1'b0, r};
                tbl_run[s]    = (k == KIND_TRIGGER) ? RS_WAIT : RS_RUN;
                tbl_pred[s]   = '0;
                res.applied   = 1'b1;
            end
            OP_START:
            begin
                if (cur == RS_WAIT)
                begin
                    tbl_run[s]   = RS_RUN;
                    tbl_count[s] = {1'b0, tbl_reload[s]};
                    res.applied  = 1'b1;
                end
            end
            OP_RESTART:
            begin
                if (cur == RS_WAIT || cur == RS_RUN)
                begin
                    tbl_run[s]   = RS_RUN;
                    tbl_count[s] = {1'b0, tbl_reload[s]};
                    res.applied  = 1'b1;
                end
            end
            OP_SET_PRED:
            begin
                if (cur != RS_EMPTY)
                begin
                    tbl_pred[s] = pe ? {1'b1, p} : 5'd0;
                    res.applied = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.status = slot_status(s);
        return res;
    endfunction

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(apply_command(opcode, slot, task_type,
                                                        reload_ticks, prev_slot,
                                                        prev_enable));
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("Unexpected result: fired_mask=%h slot_state=%0d accepted=%0b",
                                 fired_mask, slot_state, accepted);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (fired_mask !== want.fired || slot_state !== want.status
                        || accepted !== want.applied)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("Mismatch: expected fired_mask=%h slot_state=%0d accepted=%0b, got fired_mask=%h slot_state=%0d accepted=%0b",
                                     want.fired, want.status, want.applied,
                                     fired_mask, slot_state, accepted);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(
        input logic [2:0]  op,
        input logic [3:0]  s,
        input logic [2:0]  k,
        input logic [15:0] r,
        input logic [3:0]  p,
        input logic        pe
    );
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        slot         <= s;
        task_type    <= k;
        reload_ticks <= r;
        prev_slot    <= p;
        prev_enable  <= pe;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_reload();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return 16'($urandom_range(6));
        end
        else if (pick < 90)
        begin
            return 16'($urandom_range(40));
        end
        return 16'($urandom_range(65535));
    endfunction

    task automatic test_empty_and_unknown();
        send_item(OP_TICK, 4'd0, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_START, 4'd0, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_RESTART, 4'd15, 3'd7, 16'hFFFF, 4'd15, 1'b1);
        send_item(OP_SET_PRED, 4'd7, 3'd0, 16'd0, 4'd3, 1'b1);
        send_item(3'd5, 4'd0, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(3'd7, 4'd15, 3'd7, 16'hFFFF, 4'd15, 1'b1);
    endtask

    task automatic test_task_types();
        send_item(OP_CREATE, 4'd0, KIND_CYCLIC, 16'd0, 4'd0, 1'b0);
        send_item(OP_CREATE, 4'd1, KIND_ONE_TIME, 16'd2, 4'd0, 1'b0);
        send_item(OP_CREATE, 4'd2, KIND_TRIGGER, 16'd1, 4'd0, 1'b0);
        send_item(OP_CREATE, 4'd15, 3'd7, 16'hFFFF, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_START, 4'd2, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd2, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd1, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_RESTART, 4'd1, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_START, 4'd0, 3'd0, 16'd0, 4'd0, 1'b0);
    endtask

    task automatic test_predecessors();
        send_item(OP_CREATE, 4'd3, KIND_FOLLOW_ONCE, 16'd1, 4'd0, 1'b0);
        send_item(OP_SET_PRED, 4'd3, 3'd0, 16'd0, 4'd1, 1'b1);
        send_item(OP_CREATE, 4'd4, KIND_FOLLOW_CYCLIC, 16'd0, 4'd0, 1'b0);
        send_item(OP_SET_PRED, 4'd4, 3'd0, 16'd0, 4'd9, 1'b1);
        send_item(OP_CREATE, 4'd5, KIND_FOLLOW_ONCE, 16'd0, 4'd0, 1'b0);
        send_item(OP_SET_PRED, 4'd5, 3'd0, 16'd0, 4'd5, 1'b1);
        send_item(OP_SET_PRED, 4'd0, 3'd0, 16'd0, 4'd2, 1'b1);
        send_item(OP_TICK, 4'd3, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_SET_PRED, 4'd4, 3'd0, 16'd0, 4'd9, 1'b0);
        send_item(OP_TICK, 4'd4, 3'd0, 16'd0, 4'd0, 1'b0);
        send_item(OP_CREATE, 4'd0, KIND_ONE_TIME, 16'd3, 4'd0, 1'b0);
    endtask

    // Three rounds in ten build a predecessor and a follow-up and then send between one and
    // eight ticks; the other rounds send a single random command.
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          n_ticks;
        logic [3:0]  first;
        logic [3:0]  second;
        logic [2:0]  op;
        logic [2:0]  k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 30)
            begin
                first   = 4'($urandom_range(15));
                second  = 4'($urandom_range(15));
                n_ticks = $urandom_range(1, 8);
                send_item(OP_CREATE, first, 3'($urandom_range(2)), 16'($urandom_range(4)),
                          4'($urandom_range(15)), 1'($urandom_range(1)));
                send_item(OP_CREATE, second, $urandom_range(1) ? KIND_FOLLOW_CYCLIC
                          : KIND_FOLLOW_ONCE, 16'($urandom_range(4)),
                          4'($urandom_range(15)), 1'($urandom_range(1)));
                send_item(OP_SET_PRED, second, 3'($urandom_range(7)), pick_reload(),
                          first, 1'b1);
                repeat (n_ticks)
                begin
                    send_item(OP_TICK, 4'($urandom_range(15)), 3'($urandom_range(7)),
                              16'($urandom_range(65535)), 4'($urandom_range(15)),
                              1'($urandom_range(1)));
                end
                sent += 3 + n_ticks;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    op = OP_TICK;
                end
                else if (pick < 58)
                begin
                    op = OP_CREATE;
                end
                else if (pick < 68)
                begin
                    op = OP_START;
                end
                else if (pick < 78)
                begin
                    op = OP_RESTART;
                end
                else if (pick < 92)
                begin
                    op = OP_SET_PRED;
                end
                else
                begin
                    op = 3'($urandom_range(5, 7));
                end
                k = ($urandom_range(99) < 85) ? 3'($urandom_range(4))
                    : 3'($urandom_range(5, 7));
                send_item(op, 4'($urandom_range(15)), k, pick_reload(),
                          4'($urandom_range(15)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        error_count    = 0;
        send_gap_pct   = 22;
        recv_stall_pct = 50;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_TICK;
        slot         <= '0;
        task_type    <= '0;
        reload_ticks <= '0;
        prev_slot    <= '0;
        prev_enable  <= 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_pred[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unknown();
        test_task_types();
        test_predecessors();
        test_random_traffic(600);

        send_gap_pct   = 50;
        recv_stall_pct = 22;
        test_random_traffic(600);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_traffic(600);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SLOTS + 8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tick_task_timer_slots_core test passed");
        end
        else
        begin
            $display("tick_task_timer_slots_core test failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/tts_pkg.sv
sv/tts_ram.sv
sv/tts_seq.sv
sv/tick_task_timer_slots_core.sv
sv/tts_checker.sv
tb/sv/tick_task_timer_slots_core_test.sv
